FILE: hw/rtl/seven_segment_scan_display_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the seven-segment scan display
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DISPLAY_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DISPLAY_ASSERT_SVH

`ifndef SYNTHESIS

`define SSSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SSSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SSSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define SSSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/sssd_pkg.sv
// ---------------------------------------------------------------------------
// Seven-segment scan display package
// Request codes, digit codes, port bit positions and segment tables.
// ---------------------------------------------------------------------------
`default_nettype none

package sssd_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_SHOW  = 2'd1,
        REQ_POINT = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    localparam logic [7:0] CODE_BLANK   = 8'h20;
    localparam logic [7:0] CODE_MINUS   = 8'd16;
    localparam logic [7:0] CODE_E       = 8'd14;
    localparam logic [7:0] CODE_POINT   = 8'h80;
    localparam logic [7:0] PC_POINT_BIT = 8'h20;
    localparam logic [7:0] PA_ANODE_0   = 8'h08;
    localparam logic [7:0] PD_ANODE_1   = 8'h40;
    localparam logic [7:0] PD_ANODE_2   = 8'h10;
    localparam logic [7:0] PD_ANODE_3   = 8'h02;
    localparam logic [7:0] PA_SEG_OFF   = 8'h02;
    localparam logic [7:0] PB_SEG_OFF   = 8'h30;
    localparam logic [7:0] PC_SEG_OFF   = 8'hF8;

    localparam logic signed [15:0] VALUE_MIN = -16'sd999;
    localparam logic signed [15:0] VALUE_MAX = 16'sd9999;

    typedef struct packed {
        logic [7:0] pa;
        logic [7:0] pb;
        logic [7:0] pc;
    } t_seg;

    // Glyphs 0 to 15 are hex digits, 16 is a minus and 17 is 'h'.
    function automatic t_seg glyph_segments(input logic [6:0] glyph);
        t_seg s;
        s = '{pa: PA_SEG_OFF, pb: PB_SEG_OFF, pc: PC_SEG_OFF};
        unique case (glyph)
            7'd0:    s = '{pa: 8'd0, pb: 8'd0,  pc: 8'd40};
            7'd1:    s = '{pa: 8'd2, pb: 8'd32, pc: 8'd232};
            7'd2:    s = '{pa: 8'd2, pb: 8'd0,  pc: 8'd48};
            7'd3:    s = '{pa: 8'd2, pb: 8'd0,  pc: 8'd160};
            7'd4:    s = '{pa: 8'd0, pb: 8'd32, pc: 8'd224};
            7'd5:    s = '{pa: 8'd0, pb: 8'd16, pc: 8'd160};
            7'd6:    s = '{pa: 8'd0, pb: 8'd16, pc: 8'd32};
            7'd7:    s = '{pa: 8'd2, pb: 8'd0,  pc: 8'd232};
            7'd8:    s = '{pa: 8'd0, pb: 8'd0,  pc: 8'd32};
            7'd9:    s = '{pa: 8'd0, pb: 8'd0,  pc: 8'd160};
            7'd10:   s = '{pa: 8'd0, pb: 8'd0,  pc: 8'd96};
            7'd11:   s = '{pa: 8'd0, pb: 8'd48, pc: 8'd32};
            7'd12:   s = '{pa: 8'd0, pb: 8'd16, pc: 8'd56};
            7'd13:   s = '{pa: 8'd2, pb: 8'd32, pc: 8'd32};
            7'd14:   s = '{pa: 8'd0, pb: 8'd16, pc: 8'd48};
            7'd15:   s = '{pa: 8'd0, pb: 8'd16, pc: 8'd112};
            7'd16:   s = '{pa: 8'd2, pb: 8'd48, pc: 8'd240};
            7'd17:   s = '{pa: 8'd0, pb: 8'd48, pc: 8'd96};
            default: s = '{pa: PA_SEG_OFF, pb: PB_SEG_OFF, pc: PC_SEG_OFF};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/seven_segment_scan_display.sv
// ---------------------------------------------------------------------------
// Seven-segment scan display
// Four-digit common-anode display controller with decimal value loading.
// ---------------------------------------------------------------------------
// One transaction is taken in every cycle unless the input stalls. Each
// transaction is held in an input register and handled there; a scan tick
// loads its port bytes into the result register, which presents them, while
// loads, point and clear transactions finish without a result. The input
// stalls only when a tick is waiting and the result register still holds a
// transaction that has not been taken.
`default_nettype none

`include "seven_segment_scan_display_assert.svh"

module seven_segment_scan_display
    import sssd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [15:0] i_value,
    input  wire logic [1:0]         i_position,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [7:0]              o_port_a,
    output logic [7:0]              o_port_b,
    output logic [7:0]              o_port_c,
    output logic [7:0]              o_port_d,
    output logic [1:0]              o_digit_shown
);

    logic               r_s1_valid;
    t_req               r_s1_req;
    logic signed [15:0] r_s1_value;
    logic [1:0]         r_s1_position;

    logic [7:0] r_codes [4];
    logic [7:0] n_codes [4];
    logic [1:0] r_scan_index;
    logic [1:0] n_scan_index;

    logic       r_out_valid;
    logic [7:0] r_port_a;
    logic [7:0] r_port_b;
    logic [7:0] r_port_c;
    logic [7:0] r_port_d;
    logic [1:0] r_digit_shown;

    logic w_out_free;
    logic w_s1_fire;
    logic w_tick_fire;
    logic w_reload_fire;

    logic               w_out_range;
    logic               w_neg;
    logic signed [15:0] w_abs;
    logic [13:0]        w_mag;
    logic [28:0]        w_p10;
    logic [26:0]        w_p100;
    logic [28:0]        w_p1000;
    logic [9:0]         w_q1;
    logic [6:0]         w_q2;
    logic [3:0]         w_q3;
    logic [13:0]        w_r0;
    logic [13:0]        w_r1;
    logic [13:0]        w_r2;
    logic [7:0]         w_dec [4];

    logic [7:0] w_code;
    t_seg       w_seg;
    logic [7:0] n_port_a;
    logic [7:0] n_port_c;
    logic [7:0] n_port_d;
    logic [3:0] w_anodes;
    logic [1:0] w_scan_prev;

    assign w_out_free    = !r_out_valid || i_out_ready;
    assign w_s1_fire     = r_s1_valid && ((r_s1_req != REQ_TICK) || w_out_free);
    assign w_tick_fire   = w_s1_fire && (r_s1_req == REQ_TICK);
    assign w_reload_fire = w_s1_fire && (r_s1_req == REQ_SHOW || r_s1_req == REQ_CLEAR);
    assign o_in_ready    = !r_s1_valid || w_s1_fire;

    // Decimal digits come from constant reciprocal multiplies that are exact
    // for magnitudes up to 9999.
    always_comb begin
        w_out_range = (r_s1_value < VALUE_MIN) || (r_s1_value > VALUE_MAX);
        w_neg       = r_s1_value[15];
        w_abs       = w_neg ? -r_s1_value : r_s1_value;
        w_mag       = w_abs[13:0];
        w_p10       = 29'(w_mag) * 29'd52429;
        w_p100      = 27'(w_mag) * 27'd5243;
        w_p1000     = 29'(w_mag) * 29'd16778;
        w_q1        = w_p10[28:19];
        w_q2        = w_p100[25:19];
        w_q3        = w_p1000[27:24];
        w_r0        = w_mag - 14'(w_q1) * 14'd10;
        w_r1        = 14'(w_q1) - 14'(w_q2) * 14'd10;
        w_r2        = 14'(w_q2) - 14'(w_q3) * 14'd10;
        w_dec[3]    = {4'd0, w_r0[3:0]};
        w_dec[2]    = {4'd0, w_r1[3:0]};
        w_dec[1]    = {4'd0, w_r2[3:0]};
        w_dec[0]    = {4'd0, w_q3};
    end

    always_comb begin
        n_codes      = r_codes;
        n_scan_index = r_scan_index;
        unique case (r_s1_req)
            REQ_TICK: begin
                n_scan_index = r_scan_index + 2'd1;
            end
            REQ_SHOW: begin
                n_scan_index = 2'd0;
                for (int k = 0; k < 4; k++) begin
                    n_codes[k] = CODE_BLANK;
                end
                if (w_out_range) begin
                    n_codes[0] = CODE_MINUS;
                    n_codes[1] = CODE_MINUS;
                    n_codes[2] = CODE_MINUS;
                    n_codes[3] = CODE_E;
                end else if (w_mag >= 14'd1000) begin
                    n_codes = w_dec;
                end else if (w_mag >= 14'd100) begin
                    n_codes[1] = w_dec[1];
                    n_codes[2] = w_dec[2];
                    n_codes[3] = w_dec[3];
                    if (w_neg) begin
                        n_codes[0] = CODE_MINUS;
                    end
                end else if (w_mag >= 14'd10) begin
                    n_codes[2] = w_dec[2];
                    n_codes[3] = w_dec[3];
                    if (w_neg) begin
                        n_codes[1] = CODE_MINUS;
                    end
                end else begin
                    n_codes[3] = w_dec[3];
                    if (w_neg) begin
                        n_codes[2] = CODE_MINUS;
                    end
                end
            end
            REQ_POINT: begin
                n_codes[r_s1_position] = r_codes[r_s1_position] | CODE_POINT;
            end
            REQ_CLEAR: begin
                n_scan_index = 2'd0;
                for (int k = 0; k < 4; k++) begin
                    n_codes[k] = CODE_BLANK;
                end
            end
            default: begin
                n_scan_index = r_scan_index;
            end
        endcase
    end

    always_comb begin
        w_code   = r_codes[r_scan_index];
        w_seg    = glyph_segments(w_code[6:0]);
        n_port_a = w_seg.pa;
        n_port_c = w_code[7] ? (w_seg.pc ^ PC_POINT_BIT) : w_seg.pc;
        n_port_d = 8'd0;
        unique case (r_scan_index)
            2'd0:    n_port_a = w_seg.pa | PA_ANODE_0;
            2'd1:    n_port_d = PD_ANODE_1;
            2'd2:    n_port_d = PD_ANODE_2;
            default: n_port_d = PD_ANODE_3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_scan_index <= 2'd0;
            for (int k = 0; k < 4; k++) begin
                r_codes[k] <= CODE_BLANK;
            end
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_s1_fire) begin
                r_codes      <= n_codes;
                r_scan_index <= n_scan_index;
            end
            if (w_tick_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_req      <= t_req'(i_req_type);
            r_s1_value    <= i_value;
            r_s1_position <= i_position;
        end
        if (w_tick_fire) begin
            r_port_a      <= n_port_a;
            r_port_b      <= w_seg.pb;
            r_port_c      <= n_port_c;
            r_port_d      <= n_port_d;
            r_digit_shown <= r_scan_index;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_port_a      = r_port_a;
    assign o_port_b      = r_port_b;
    assign o_port_c      = r_port_c;
    assign o_port_d      = r_port_d;
    assign o_digit_shown = r_digit_shown;

    assign w_anodes    = {o_port_a[3], o_port_d[6], o_port_d[4], o_port_d[1]};
    assign w_scan_prev = r_scan_index - 2'd1;

    `SSSD_ASSERT_NEXT(a_tick_loads, i_clk, i_rst_n, w_tick_fire, r_out_valid, "tick lost")
    `SSSD_ASSERT_NEXT(a_shown, i_clk, i_rst_n, w_tick_fire, r_digit_shown == w_scan_prev, "digit")
    `SSSD_ASSERT_NEXT(a_reload, i_clk, i_rst_n, w_reload_fire, r_scan_index == 2'd0, "no restart")
    `SSSD_ASSERT_IMPLY(a_one_anode, i_clk, i_rst_n, r_out_valid, $onehot(w_anodes), "anodes")

endmodule

`default_nettype wire

FILE: dv/seven_segment_scan_display_tb.sv
// ---------------------------------------------------------------------------
// Seven-segment scan display testbench
// Drives value loads, point sets, clears and scan ticks into the controller
// and checks every port frame against a digit buffer kept in step with the
// accepted transactions, under three patterns of stalls on both channels.
// ---------------------------------------------------------------------------
module seven_segment_scan_display_tb
    import sssd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_GUARD  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 530;

    typedef struct packed {
        logic [7:0] port_a;
        logic [7:0] port_b;
        logic [7:0] port_c;
        logic [7:0] port_d;
        logic [1:0] digit;
    } t_scan_frame;

    class display_scoreboard;
        logic [7:0]  codes [4];
        logic [1:0]  scan_idx;
        logic [7:0]  seg_a [18];
        logic [7:0]  seg_b [18];
        logic [7:0]  seg_c [18];
        t_scan_frame frames_due [$];
        int          mismatches;
        int          frames_checked;
        int          items_noted;
        int          loads;
        int          range_errors;
        int          point_sets;
        int          clears;

        function new();
            seg_a = '{0, 2, 2, 2, 0, 0, 0, 2, 0, 0, 0, 0, 0, 2, 0, 0, 2, 0};
            seg_b = '{0, 32, 0, 0, 32, 16, 16, 0, 0, 0, 0, 48, 16, 32, 16, 16, 48, 48};
            seg_c = '{40, 232, 48, 160, 224, 160, 32, 232, 32, 160, 96, 32, 56, 32, 48,
                      112, 240, 96};
            mismatches     = 0;
            frames_checked = 0;
            items_noted    = 0;
            loads          = 0;
            range_errors   = 0;
            point_sets     = 0;
            clears         = 0;
            blank_buffer();
        endfunction

        function void blank_buffer();
            foreach (codes[k]) codes[k] = CODE_BLANK;
            scan_idx = 2'd0;
        endfunction

        function void load_value(logic signed [15:0] value);
            int v;
            int mag;
            int slot;
            v = value;
            blank_buffer();
            loads++;
            if (v < VALUE_MIN || v > VALUE_MAX) begin
                codes[0] = CODE_MINUS;
                codes[1] = CODE_MINUS;
                codes[2] = CODE_MINUS;
                codes[3] = CODE_E;
                range_errors++;
                return;
            end
            if (v == 0) begin
                codes[3] = 8'd0;
                return;
            end
            mag  = (v < 0) ? -v : v;
            slot = 3;
            while (slot >= 0 && mag != 0) begin
                codes[slot] = 8'(mag % 10);
                mag = mag / 10;
                slot--;
            end
            if (v < 0 && slot >= 0) codes[slot] = CODE_MINUS;
        endfunction

        function t_scan_frame render_digit();
            t_scan_frame f;
            logic [7:0]  code;
            logic [6:0]  glyph;
            code  = codes[scan_idx];
            glyph = code[6:0];
            f     = '0;
            if (glyph < 7'd18) begin
                f.port_a = seg_a[glyph];
                f.port_b = seg_b[glyph];
                f.port_c = seg_c[glyph];
            end else begin
                f.port_a = PA_SEG_OFF;
                f.port_b = PB_SEG_OFF;
                f.port_c = PC_SEG_OFF;
            end
            if (code[7]) f.port_c = f.port_c ^ PC_POINT_BIT;
            case (scan_idx)
                2'd0: f.port_a = f.port_a | PA_ANODE_0;
                2'd1: f.port_d = PD_ANODE_1;
                2'd2: f.port_d = PD_ANODE_2;
                default: f.port_d = PD_ANODE_3;
            endcase
            f.digit  = scan_idx;
            scan_idx = scan_idx + 2'd1;
            return f;
        endfunction

        function void note_input(t_req req, logic signed [15:0] value, logic [1:0] position);
            items_noted++;
            case (req)
                REQ_TICK:  frames_due.push_back(render_digit());
                REQ_SHOW:  load_value(value);
                REQ_POINT: begin
                    codes[position] = codes[position] | CODE_POINT;
                    point_sets++;
                end
                REQ_CLEAR: begin
                    blank_buffer();
                    clears++;
                end
                default: ;
            endcase
        endfunction

        function void check_frame(t_scan_frame got);
            t_scan_frame want;
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected frame a=%h b=%h c=%h d=%h digit=%0d", $realtime,
                             got.port_a, got.port_b, got.port_c, got.port_d, got.digit);
                return;
            end
            want = frames_due.pop_front();
            frames_checked++;
            if (got.port_a != want.port_a || got.port_b != want.port_b ||
                got.port_c != want.port_c || got.port_d != want.port_d ||
                got.digit != want.digit) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: frame mismatch expected a=%h b=%h c=%h d=%h digit=%0d, %s",
                             $realtime, want.port_a, want.port_b, want.port_c, want.port_d,
                             want.digit, $sformatf("got a=%h b=%h c=%h d=%h digit=%0d",
                             got.port_a, got.port_b, got.port_c, got.port_d, got.digit));
            end
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [1:0]         i_req_type  = REQ_TICK;
    logic signed [15:0] i_value     = '0;
    logic [1:0]         i_position  = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [7:0]         o_port_a;
    logic [7:0]         o_port_b;
    logic [7:0]         o_port_c;
    logic [7:0]         o_port_d;
    logic [1:0]         o_digit_shown;

    display_scoreboard board = new();
    int unsigned       cycle_count = 0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;

    seven_segment_scan_display dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_port_a      (o_port_a),
        .o_port_b      (o_port_b),
        .o_port_c      (o_port_c),
        .o_port_d      (o_port_d),
        .o_digit_shown (o_digit_shown)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_frame('{port_a: o_port_a, port_b: o_port_b, port_c: o_port_c,
                                port_d: o_port_d, digit: o_digit_shown});
        i_out_ready <= i_rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles.", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic signed [15:0] random_value();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = int'($urandom_range(0, 10998)) - 999;
            5:             v = int'($urandom_range(0, 20)) - 10;
            6: begin
                case ($urandom_range(0, 11))
                    0:       v = -999;
                    1:       v = -1000;
                    2:       v = 9999;
                    3:       v = 10000;
                    4:       v = -99;
                    5:       v = -100;
                    6:       v = -9;
                    7:       v = -10;
                    8:       v = 999;
                    9:       v = 1000;
                    10:      v = -32768;
                    default: v = 32767;
                endcase
            end
            default: v = int'($urandom());
        endcase
        return 16'(v);
    endfunction

    task automatic send_item(t_req req, logic signed [15:0] value, logic [1:0] position);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_value    <= value;
        i_position <= position;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(req, value, position);
    endtask

    task automatic send_tick();
        send_item(REQ_TICK, random_value(), 2'($urandom_range(0, 3)));
    endtask

    // Mostly a load or clear, a few point sets and a run of ticks; the rest is noise.
    task automatic send_random_burst();
        int n_points;
        int n_ticks;
        if ($urandom_range(0, 99) < 15) begin
            send_item(t_req'($urandom_range(0, 3)), random_value(), 2'($urandom_range(0, 3)));
        end else begin
            if ($urandom_range(0, 9) < 8)
                send_item(REQ_SHOW, random_value(), 2'($urandom_range(0, 3)));
            else
                send_item(REQ_CLEAR, random_value(), 2'($urandom_range(0, 3)));
            n_points = $urandom_range(0, 2);
            repeat (n_points) send_item(REQ_POINT, random_value(), 2'($urandom_range(0, 3)));
            n_ticks = $urandom_range(3, 9);
            repeat (n_ticks) send_tick();
        end
    endtask

    task automatic wait_for_drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (board.frames_due.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        if (board.frames_due.size() != 0) begin
            $display("%0t: %0d expected frames never arrived.", $realtime,
                     board.frames_due.size());
            board.mismatches += board.frames_due.size();
            board.frames_due.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 32;
        stall_pct     = 60;

        send_tick();
        send_item(REQ_SHOW, 16'sd0, 2'd0);
        repeat (4) send_tick();
        send_item(REQ_SHOW, VALUE_MAX, 2'd3);
        send_item(REQ_POINT, 16'sd0, 2'd0);
        send_item(REQ_POINT, 16'sd0, 2'd1);
        send_item(REQ_POINT, 16'sd0, 2'd2);
        send_item(REQ_POINT, 16'sd0, 2'd3);
        repeat (4) send_tick();
        send_item(REQ_SHOW, VALUE_MIN, 2'd1);
        repeat (4) send_tick();
        send_item(REQ_SHOW, -16'sd1000, 2'd2);
        send_tick();
        send_item(REQ_SHOW, 16'sd10000, 2'd0);
        send_tick();
        send_item(REQ_CLEAR, -16'sd1, 2'd3);
        send_tick();
        wait_for_drain();

        target = board.items_noted + PHASE_ITEMS;
        while (board.items_noted < target) send_random_burst();
        wait_for_drain();

        send_idle_pct = 60;
        stall_pct     = 32;
        target = board.items_noted + PHASE_ITEMS;
        while (board.items_noted < target) send_random_burst();
        wait_for_drain();

        send_idle_pct = 0;
        stall_pct     = 0;
        target = board.items_noted + PHASE_ITEMS;
        while (board.items_noted < target) send_random_burst();
        wait_for_drain();

        $display("Run covered %0d transactions and %0d checked digit frames.",
                 board.items_noted, board.frames_checked);
        $display("It loaded %0d values (%0d out of range), set %0d points and cleared %0d times.",
                 board.loads, board.range_errors, board.point_sets, board.clears);
        if (board.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("Mismatches: %0d", board.mismatches);
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sssd_pkg.sv
hw/rtl/seven_segment_scan_display.sv
dv/seven_segment_scan_display_tb.sv
